[rtl/ipsc_pkg.sv]
// Shared types and constants for the incremental PID speed controller.
// Holds op codes, register indexes, multiplier step codes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int VALUE_W    = 16;
    localparam int ERR_W      = 17;
    localparam int TGT_W      = 14;
    localparam int DRIVE_W    = 16;
    localparam int ACC_W      = 61;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_SETPOINT = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_UNUSED   = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_PERIOD  = 3'd4;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd328;
    localparam logic [23:0] INV_PERIOD_RST  = 24'd25600;

    localparam logic signed [VALUE_W-1:0] SP_MAX    = 16'sd6144;
    localparam logic signed [VALUE_W-1:0] SP_MIN    = -16'sd6144;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sd19660;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -16'sd19660;

    // One product per step of the shared multiplier
    typedef enum logic [2:0] {
        MS_KH = 3'd0,   // gain_integ * half_period
        MS_P  = 3'd1,   // gain_prop * first difference
        MS_D1 = 3'd2,   // gain_deriv * second difference
        MS_I  = 3'd3,   // kh * error sum
        MS_D  = 3'd4    // d1 * inv_period
    } t_mstep;

    typedef struct packed {
        logic   capture;
        logic   load;
        logic   mul_go;
        t_mstep mul_step;
        logic   sat;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_sample;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/ipsc_dp.sv]
// Datapath: configuration registers, controller state, shared multiplier,
// accumulator, saturation and output registers. Uses ipsc_pkg; driven by
// ipsc_ctrl through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module ipsc_dp
    import ipsc_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]      i_cfg_data,
    input  wire  [1:0]                 i_op,
    input  wire  signed [VALUE_W-1:0]  i_value,
    input  wire  t_dp_cmd              i_cmd,
    output t_dp_sts                    o_sts,
    output logic signed [DRIVE_W-1:0]  o_drive,
    output logic                       o_clipped,
    output logic                       o_setpoint_taken
);

    logic [23:0] r_gain_prop, r_gain_integ, r_gain_deriv, r_inv_period;
    logic [15:0] r_half_period;

    logic [1:0]                r_op;
    logic signed [VALUE_W-1:0] r_value;

    logic signed [ERR_W-1:0]   r_err_now, r_err_prev, r_err_prev2;
    logic signed [DRIVE_W-1:0] r_drive_last;
    logic signed [TGT_W-1:0]   r_target;

    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prod_vld;
    t_mstep                    r_tag;
    logic [23:0]               r_kh;
    logic signed [30:0]        r_d1;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_clip, r_taken;

    logic signed [ERR_W-1:0]   n_err;
    logic signed [17:0]        w_diff1, w_sum1;
    logic signed [18:0]        w_diff2;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [47:0]        w_s;
    logic signed [47:0]        w_lim_hi, w_lim_lo;
    logic                      w_sp_ok;

    assign o_sts.is_sample = (t_op'(r_op) == OP_SAMPLE);

    assign n_err   = ERR_W'(r_target) - ERR_W'(r_value);
    assign w_diff1 = 18'(r_err_now) - 18'(r_err_prev);
    assign w_sum1  = 18'(r_err_now) + 18'(r_err_prev);
    assign w_diff2 = 19'(r_err_now) - (19'(r_err_prev) <<< 1) + 19'(r_err_prev2);
    assign w_sp_ok = (r_value >= SP_MIN) && (r_value <= SP_MAX);

    always_comb begin
        case (i_cmd.mul_step)
            MS_KH: begin
                w_mul_a = MUL_A_W'({1'b0, r_half_period});
                w_mul_b = MUL_B_W'({1'b0, r_gain_integ});
            end
            MS_P: begin
                w_mul_a = MUL_A_W'(w_diff1);
                w_mul_b = MUL_B_W'({1'b0, r_gain_prop});
            end
            MS_D1: begin
                w_mul_a = MUL_A_W'(w_diff2);
                w_mul_b = MUL_B_W'({1'b0, r_gain_deriv});
            end
            MS_I: begin
                w_mul_a = MUL_A_W'(w_sum1);
                w_mul_b = MUL_B_W'({1'b0, r_kh});
            end
            MS_D: begin
                w_mul_a = MUL_A_W'(r_d1);
                w_mul_b = MUL_B_W'({1'b0, r_inv_period});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod   = w_mul_a * w_mul_b;
    assign w_s      = r_acc[ACC_W-1:13];
    assign w_lim_hi = 48'(DRIVE_MAX);
    assign w_lim_lo = 48'(DRIVE_MIN);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop   <= '0;
            r_gain_integ  <= '0;
            r_gain_deriv  <= '0;
            r_half_period <= HALF_PERIOD_RST;
            r_inv_period  <= INV_PERIOD_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_GAIN_PROP:   r_gain_prop   <= i_cfg_data;
                CFG_GAIN_INTEG:  r_gain_integ  <= i_cfg_data;
                CFG_GAIN_DERIV:  r_gain_deriv  <= i_cfg_data;
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data[15:0];
                CFG_INV_PERIOD:  r_inv_period  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Controller state and per-item flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_now    <= '0;
            r_err_prev   <= '0;
            r_err_prev2  <= '0;
            r_drive_last <= '0;
            r_target     <= '0;
            r_clip       <= 1'b0;
            r_taken      <= 1'b0;
        end else if (i_cmd.load) begin
            r_clip  <= 1'b0;
            r_taken <= 1'b0;
            case (t_op'(r_op))
                OP_SAMPLE: begin
                    r_err_prev2 <= r_err_prev;
                    r_err_prev  <= r_err_now;
                    r_err_now   <= n_err;
                end
                OP_SETPOINT: begin
                    if (w_sp_ok) begin
                        r_target <= r_value[TGT_W-1:0];
                        r_taken  <= 1'b1;
                    end
                end
                OP_CLEAR: begin
                    r_err_now    <= '0;
                    r_err_prev   <= '0;
                    r_err_prev2  <= '0;
                    r_drive_last <= '0;
                    r_target     <= '0;
                end
                default: ;
            endcase
        end else if (i_cmd.sat) begin
            if (w_s > w_lim_hi) begin
                r_drive_last <= DRIVE_MAX;
                r_clip       <= 1'b1;
            end else if (w_s < w_lim_lo) begin
                r_drive_last <= DRIVE_MIN;
                r_clip       <= 1'b1;
            end else begin
                r_drive_last <= w_s[DRIVE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_go;
        end
    end

    // Item capture, multiplier register, product use by step tag, output load
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
        if (i_cmd.mul_go) begin
            r_prod <= w_prod;
            r_tag  <= i_cmd.mul_step;
        end
        if (i_cmd.load) begin
            r_acc <= {{(ACC_W-DRIVE_W-13){r_drive_last[DRIVE_W-1]}}, r_drive_last, 13'b0};
        end else if (r_prod_vld) begin
            case (r_tag)
                MS_KH: r_kh  <= r_prod[39:16];
                MS_D1: r_d1  <= r_prod[42:12];
                MS_P:  r_acc <= r_acc + ACC_W'(r_prod);
                MS_I:  r_acc <= r_acc + ACC_W'(r_prod);
                MS_D:  r_acc <= r_acc + (ACC_W'(r_prod) <<< 4);
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            o_drive          <= r_drive_last;
            o_clipped        <= r_clip;
            o_setpoint_taken <= r_taken;
        end
    end

endmodule

`default_nettype wire

[rtl/ipsc_ctrl.sv]
// Controller: one-hot state machine; a speed sample goes through load,
// the five multiplier steps, accumulate drain, saturation and output;
// others skip to output. Uses ipsc_pkg; commands ipsc_dp via t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module ipsc_ctrl
    import ipsc_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  wire            i_stall,
    input  wire  t_dp_sts  i_sts,
    output t_dp_cmd        o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_SAT   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_mstep r_step, n_step;
    logic   r_out_vld, n_out_vld;
    logic   w_accept, w_out_free;

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_out_vld;
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_vld || !i_stall;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.capture  = w_accept;
        o_cmd.mul_step = r_step;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = MS_KH;
                n_state    = i_sts.is_sample ? ST_MUL : ST_OUT;
            end
            ST_MUL: begin
                o_cmd.mul_go = 1'b1;
                if (r_step == MS_D) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_step = t_mstep'(r_step + 3'd1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_SAT;
            end
            ST_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= MS_KH;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_step == MS_KH || r_step == MS_P || r_step == MS_D1 ||
                                 r_step == MS_I || r_step == MS_D))
        else $error("multiplier step out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_vld || !i_stall))
        else $error("output register overwritten while a result waits");

    a_last_step_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_step == MS_D) |=> (r_state == ST_DRAIN))
        else $error("sequence did not drain after the last product");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_LOAD))
        else $error("accepted item was not loaded");

    a_sat_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SAT) |-> ($past(r_state) == ST_DRAIN))
        else $error("saturation reached without a drain cycle");
`endif

endmodule

`default_nettype wire

[rtl/incremental_pid_speed_controller.sv]
// Incremental (velocity-form) PID speed controller, top level.
// Input channel: i_valid / o_stall carry i_op and i_value (Q3.12). An item is
// taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry o_drive (Q0.15), o_clipped and
// o_setpoint_taken; one result per input item, in order.
// Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_idx
// (0 gain_prop, 1 gain_integ, 2 gain_deriv, 3 half_period, 4 inv_period).
// Write only while the block is idle.
// Sequence: a speed sample goes through load, five multiplier steps, drain,
// saturation and output; setpoint, clear and unused codes go from load
// straight to output. No new item is taken until the block is idle. The
// single shared 32x25 multiplier forms the five products in turn.
// The finished result sits in an output register, so a stalled receiver
// holds o_valid and the payload while the block goes idle; the next result
// waits in the controller until that register is taken.
// Reset (synchronous, i_rst_n low) clears the errors, the last drive and the
// setpoint, and puts the registers at their reset values.
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_speed_controller
    import ipsc_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire  [1:0]                 i_op,
    input  wire  signed [VALUE_W-1:0]  i_value,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic signed [DRIVE_W-1:0]  o_drive,
    output logic                       o_clipped,
    output logic                       o_setpoint_taken
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ipsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ipsc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_op),
        .i_value          (i_value),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_drive          (o_drive),
        .o_clipped        (o_clipped),
        .o_setpoint_taken (o_setpoint_taken)
    );

endmodule

`default_nettype wire

[test/incremental_pid_speed_controller_tb.sv]
// Self-checking testbench for incremental_pid_speed_controller: a fixed-point drive
// predictor is checked against every result, with random handshake gaps and register phases.
// Depends on ipsc_pkg and the controller RTL only.
`timescale 1ns / 1ps

module incremental_pid_speed_controller_tb;
    import ipsc_pkg::*;

    localparam int SETTLE_CYCLES   = 12;
    localparam int END_CYCLES      = 20;
    localparam int IDLE_LIMIT      = 1000;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int MODE_RUN        = 35;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX    = 16'sh7FFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN    = 16'sh8000;
    localparam logic [CFG_DATA_W-1:0]     CFG_ALL_ONES = '1;
    localparam logic [15:0]               HALF_ALL_ONES = '1;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               clipped;
        logic               taken;
    } t_drive_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [CFG_DATA_W-1:0]      i_cfg_data;
    logic                       i_valid;
    logic                       o_stall;
    logic [1:0]                 i_op;
    logic signed [VALUE_W-1:0]  i_value;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [DRIVE_W-1:0]  o_drive;
    logic                       o_clipped;
    logic                       o_setpoint_taken;

    // Register mirror
    logic [CFG_DATA_W-1:0] kp_q816, ki_q816, kd_q816, inv_ts_q168;
    logic [15:0]           half_ts_q016;

    // Controller state mirror
    logic signed [ERR_W-1:0]   err_cur, err_last, err_last2;
    logic signed [DRIVE_W-1:0] drive_now;
    logic signed [TGT_W-1:0]   sp_target;

    t_drive_result expected_drive_q[$];
    int items_sent, results_checked, clipped_seen, taken_seen, mismatches;
    bit tx_steady, rx_steady;

    incremental_pid_speed_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_drive          (o_drive),
        .o_clipped        (o_clipped),
        .o_setpoint_taken (o_setpoint_taken)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Advance the mirrored state by one item and return the drive it reports
    function automatic t_drive_result predict_drive(input t_op op,
                                                    input logic signed [VALUE_W-1:0] value);
        t_drive_result r;
        longint v, diff, e, ep, ep2, p_term, kh, i_term, d1, d_term, s;
        r.clipped = 1'b0;
        r.taken   = 1'b0;
        v = value;
        case (op)
            OP_SAMPLE: begin
                err_last2 = err_last;
                err_last  = err_cur;
                diff      = longint'(sp_target) - v;
                err_cur   = diff[ERR_W-1:0];
                e   = err_cur;
                ep  = err_last;
                ep2 = err_last2;
                p_term = longint'(kp_q816) * (e - ep);
                kh     = (longint'(ki_q816) * longint'(half_ts_q016)) >>> 16;
                i_term = kh * (e + ep);
                d1     = (longint'(kd_q816) * (e - 2 * ep + ep2)) >>> 12;
                d_term = d1 * longint'(inv_ts_q168) * 16;
                s = (longint'(drive_now) * 8192 + p_term + i_term + d_term) >>> 13;
                if (s > longint'(DRIVE_MAX)) begin
                    s = DRIVE_MAX;
                    r.clipped = 1'b1;
                end else if (s < longint'(DRIVE_MIN)) begin
                    s = DRIVE_MIN;
                    r.clipped = 1'b1;
                end
                drive_now = s[DRIVE_W-1:0];
            end
            OP_SETPOINT: begin
                if (v >= longint'(SP_MIN) && v <= longint'(SP_MAX)) begin
                    sp_target = value[TGT_W-1:0];
                    r.taken   = 1'b1;
                end
            end
            OP_CLEAR: begin
                err_cur   = '0;
                err_last  = '0;
                err_last2 = '0;
                drive_now = '0;
                sp_target = '0;
            end
            default: ;
        endcase
        r.drive = drive_now;
        return r;
    endfunction

    task automatic send_item(input t_op op, input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_value <= value;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        expected_drive_q.push_back(predict_drive(op, value));
        items_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then wait out the caller's extra settling time
    task automatic settle_block(input int extra);
        i_valid <= 1'b0;
        while (expected_drive_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                               input logic [CFG_DATA_W-1:0] kd, input logic [15:0] half_ts,
                               input logic [CFG_DATA_W-1:0] inv_ts, input bit touch_spare);
        cfg_write(CFG_GAIN_PROP, kp);
        cfg_write(CFG_GAIN_INTEG, ki);
        cfg_write(CFG_GAIN_DERIV, kd);
        cfg_write(CFG_HALF_PERIOD, {{(CFG_DATA_W - 16){1'b0}}, half_ts});
        cfg_write(CFG_INV_PERIOD, inv_ts);
        // Unmapped indexes must leave every register alone
        if (touch_spare) begin
            for (int k = CFG_INV_PERIOD + 1; k < (1 << CFG_IDX_W); k++)
                cfg_write(k[CFG_IDX_W-1:0], CFG_ALL_ONES);
        end
        i_cfg_wr_en <= 1'b0;
        kp_q816      = kp;
        ki_q816      = ki;
        kd_q816      = kd;
        half_ts_q016 = half_ts;
        inv_ts_q168  = inv_ts;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        int bits;
        logic [31:0] raw;
        bits = $urandom_range(0, CFG_DATA_W);
        raw  = $urandom() & ((32'd1 << bits) - 32'd1);
        return raw[CFG_DATA_W-1:0];
    endfunction

    // Mostly track the setpoint with small noise, sometimes jump anywhere
    function automatic logic signed [VALUE_W-1:0] pick_speed();
        int kind, span, sum;
        logic [31:0] raw;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            span = 1 << $urandom_range(0, 11);
            sum  = int'(sp_target) + int'($urandom_range(0, 2 * span)) - span;
            return sum[VALUE_W-1:0];
        end
        if (kind < 92) begin
            raw = $urandom();
            return raw[VALUE_W-1:0];
        end
        return kind[0] ? VALUE_MAX : VALUE_MIN;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_setpoint();
        int kind, sum;
        logic [31:0] raw;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            sum = int'($urandom_range(0, 2 * 6144)) + int'(SP_MIN);
            return sum[VALUE_W-1:0];
        end
        case (kind % 4)
            0: return SP_MAX;
            1: return SP_MIN;
            2: return kind[3] ? SP_MAX + 16'sd1 : SP_MIN - 16'sd1;
            default: begin
                raw = $urandom();
                return raw[VALUE_W-1:0];
            end
        endcase
    endfunction

    task automatic test_reset_state();
        // Gains are zero out of reset, so the drive must stay at zero
        send_item(OP_SAMPLE, VALUE_MAX);
        send_item(OP_SAMPLE, VALUE_MIN);
    endtask

    task automatic test_setpoint_limits();
        send_item(OP_SETPOINT, SP_MAX);
        send_item(OP_SETPOINT, SP_MAX + 16'sd1);
        send_item(OP_SETPOINT, SP_MIN);
        send_item(OP_SETPOINT, SP_MIN - 16'sd1);
        send_item(OP_SETPOINT, VALUE_MAX);
        send_item(OP_SETPOINT, VALUE_MIN);
        send_item(OP_UNUSED, VALUE_MIN);
        send_item(OP_CLEAR, VALUE_MAX);
    endtask

    task automatic test_saturation();
        settle_block(SETTLE_CYCLES);
        load_config(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, HALF_ALL_ONES, CFG_ALL_ONES, 1'b0);
        send_item(OP_SETPOINT, SP_MAX);
        send_item(OP_SAMPLE, VALUE_MIN);
        send_item(OP_SAMPLE, VALUE_MAX);
        send_item(OP_SAMPLE, 16'sd0);
        send_item(OP_CLEAR, 16'sd0);
        send_item(OP_SAMPLE, 16'sd0);
    endtask

    task automatic test_single_terms();
        settle_block(SETTLE_CYCLES);
        // Unity proportional gain; spare writes of all ones follow and must not stick
        load_config(24'h010000, '0, '0, HALF_PERIOD_RST, INV_PERIOD_RST, 1'b1);
        send_item(OP_SETPOINT, 16'sd4096);
        send_item(OP_SAMPLE, 16'sd4000);
        send_item(OP_SAMPLE, 16'sd4096);
        send_item(OP_SAMPLE, 16'sd4200);
        settle_block(SETTLE_CYCLES);
        load_config('0, 24'h020000, 24'h000400, HALF_PERIOD_RST, INV_PERIOD_RST, 1'b0);
        send_item(OP_SAMPLE, 16'sd3000);
        send_item(OP_SAMPLE, 16'sd5000);
        send_item(OP_SAMPLE, 16'sd4100);
    endtask

    task automatic test_random_tracking();
        int pick;
        logic [31:0] raw;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            settle_block(SETTLE_CYCLES);
            if (phase == 0) begin
                load_config('0, '0, '0, '0, '0, 1'b0);
            end else if (phase == RAND_PHASES - 1) begin
                load_config(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, HALF_ALL_ONES,
                            CFG_ALL_ONES, 1'b0);
            end else begin
                raw = $urandom();
                load_config(pick_gain(), pick_gain(), pick_gain(), raw[15:0], pick_gain(),
                            phase == 2);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % MODE_RUN == 0) begin
                    tx_steady = ($urandom_range(0, 2) == 0);
                    rx_steady = ($urandom_range(0, 2) == 0);
                end
                // Hold the sender until the block has drained
                if (n == ITEMS_PER_PHASE / 2)
                    settle_block(0);
                raw  = $urandom();
                pick = $urandom_range(0, 99);
                if (pick < 78)
                    send_item(OP_SAMPLE, pick_speed());
                else if (pick < 90)
                    send_item(OP_SETPOINT, pick_setpoint());
                else if (pick < 95)
                    send_item(OP_CLEAR, raw[VALUE_W-1:0]);
                else
                    send_item(OP_UNUSED, raw[VALUE_W-1:0]);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver: random stall before each result unless rx_steady is set, then check it against the oldest prediction
    initial begin : drive_sink
        int stall_len;
        t_drive_result want;
        i_stall = 1'b0;
        forever begin
            stall_len = rx_steady ? 0 : $urandom_range(0, 8);
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_stall === 1'b0));
            if (expected_drive_q.size() == 0) begin
                $display("%0t: unexpected result drive %0d clipped %b taken %b",
                         $time, o_drive, o_clipped, o_setpoint_taken);
                mismatches++;
            end else begin
                want = expected_drive_q.pop_front();
                results_checked++;
                if (o_drive !== want.drive) begin
                    $display("%0t: drive expected %0d got %0d",
                             $time, $signed(want.drive), o_drive);
                    mismatches++;
                end
                if (o_clipped !== want.clipped) begin
                    $display("%0t: clipped expected %b got %b", $time, want.clipped, o_clipped);
                    mismatches++;
                end
                if (o_setpoint_taken !== want.taken) begin
                    $display("%0t: setpoint_taken expected %b got %b",
                             $time, want.taken, o_setpoint_taken);
                    mismatches++;
                end
                clipped_seen += want.clipped;
                taken_seen   += want.taken;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, expected_drive_q.size());
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_op         = OP_SAMPLE;
        i_value      = '0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_idx    = CFG_GAIN_PROP;
        i_cfg_data   = '0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        kp_q816      = '0;
        ki_q816      = '0;
        kd_q816      = '0;
        half_ts_q016 = HALF_PERIOD_RST;
        inv_ts_q168  = INV_PERIOD_RST;
        err_cur      = '0;
        err_last     = '0;
        err_last2    = '0;
        drive_now    = '0;
        sp_target    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_setpoint_limits();
        test_saturation();
        test_single_terms();
        test_random_tracking();

        settle_block(END_CYCLES);
        $display("Sent %0d items over %0d register phases; checked %0d results",
                 items_sent, RAND_PHASES + 3, results_checked);
        $display("Saw %0d clipped drives and %0d taken setpoints; %0d mismatches",
                 clipped_seen, taken_seen, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
